// ===== rtl/lzrtf_pkg.sv =====
// ----------------------------------------------------------------------------
// lzrtf_pkg
// Shared constants, types and the dictionary prefix for the compressed-RTF
// stream decompressor.
// ----------------------------------------------------------------------------
package lzrtf_pkg;

    localparam int WINDOW_SIZE   = 4096;
    localparam int PREFIX_LENGTH = 207;
    localparam int WIN_AW        = $clog2(WINDOW_SIZE);
    localparam int POS_W         = 33;   // absolute write position
    localparam int CNT_W         = 32;   // produced / raw length
    localparam int LEN_W         = 5;    // copy length, up to 17

    localparam logic [31:0] FMT_PLAIN = 32'h414c454d;
    localparam logic [31:0] FMT_LZ    = 32'h75465a4c;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_SHORT  = 2'd1,
        STATUS_FORMAT = 2'd2
    } status_t;

    // window write port, also seen by the copy unit for forwarding
    typedef struct packed {
        logic              en;
        logic [WIN_AW-1:0] addr;
        logic [7:0]        data;
    } win_wr_t;

    // copy request from the token parser
    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] off;
        logic [LEN_W-1:0] len;
        logic             ends;   // copy reaches the raw length
    } copy_cmd_t;

    // preset window contents, first character in the top byte
    localparam logic [8*PREFIX_LENGTH-1:0] DICT_TEXT = {
        "{\\rtf1\\ansi\\mac\\deff0\\deftab720{\\fonttbl;}",
        "{\\f0\\fnil \\froman \\fswiss \\fmodern \\fscript ",
        "\\fdecor MS Sans SerifSymbolArialTimes New RomanCourier",
        "{\\colortbl\\red0\\green0\\blue0\015\012\\par ",
        "\\pard\\plain\\f0\\fs20\\b\\i\\u\\tab\\tx"
    };

    function automatic logic [7:0] dict_byte(input logic [7:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (int'(idx) < PREFIX_LENGTH) begin
            b = DICT_TEXT[8*(PREFIX_LENGTH-1-int'(idx)) +: 8];
        end
        return b;
    endfunction

endpackage

// ===== rtl/lzrtf_window_ram.sv =====
// ----------------------------------------------------------------------------
// lzrtf_window_ram
// 4096 x 8 ring window, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lzrtf_window_ram (
    input  logic                        clk,
    input  lzrtf_pkg::win_wr_t          wr,
    input  logic                        rd_en,
    input  logic [lzrtf_pkg::WIN_AW-1:0] rd_addr,
    output logic [7:0]                  rd_data
);
    import lzrtf_pkg::*;

    logic [7:0] mem [WINDOW_SIZE];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read-before-write on a same-address collision
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/lzrtf_copy_unit.sv =====
// ----------------------------------------------------------------------------
// lzrtf_copy_unit
// Back-reference copy engine: issues one window read per cycle unless held by
// a stalled output, delivering the registered byte, with write forwarding.
// ----------------------------------------------------------------------------
module lzrtf_copy_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lzrtf_pkg::copy_cmd_t cmd,
    input  lzrtf_pkg::win_wr_t   wr,
    input  logic                 take,
    output logic                 cu_valid,
    output logic [7:0]           cu_data,
    output logic                 cu_last,
    output logic                 busy
);
    import lzrtf_pkg::*;

    logic [LEN_W-1:0] left_reg;
    logic [POS_W-1:0] off_reg;
    logic             ends_reg;
    logic             s2_valid_reg;
    logic             s2_dict_reg;
    logic [7:0]       s2_idx_reg;
    logic             s2_fwd_reg;
    logic [7:0]       s2_fwd_data_reg;
    logic             s2_last_reg;
    logic [7:0]       ram_q;
    logic             issue;
    logic             in_dict;

    assign issue   = (left_reg != '0) && (!s2_valid_reg || take);
    // positions below the prefix end are never rewritten within a stream
    assign in_dict = off_reg < POS_W'(PREFIX_LENGTH);

    lzrtf_window_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (issue),
        .rd_addr (off_reg[WIN_AW-1:0]),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg     <= '0;
            off_reg      <= '0;
            ends_reg     <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                left_reg <= cmd.len;
                off_reg  <= cmd.off;
                ends_reg <= cmd.ends;
            end
            else if (issue)
            begin
                left_reg <= left_reg - LEN_W'(1);
                off_reg  <= off_reg + POS_W'(1);
            end

            if (issue)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s2_dict_reg     <= in_dict;
            s2_idx_reg      <= off_reg[7:0];
            s2_fwd_reg      <= wr.en && (wr.addr == off_reg[WIN_AW-1:0]);
            s2_fwd_data_reg <= wr.data;
            s2_last_reg     <= ends_reg && (left_reg == LEN_W'(1));
        end
    end

    always_comb
    begin
        if (s2_dict_reg)
        begin
            cu_data = dict_byte(s2_idx_reg);
        end
        else if (s2_fwd_reg)
        begin
            cu_data = s2_fwd_data_reg;
        end
        else
        begin
            cu_data = ram_q;
        end
    end

    assign cu_valid = s2_valid_reg;
    assign cu_last  = s2_last_reg;
    assign busy     = (left_reg != '0) || s2_valid_reg;

endmodule

// ===== rtl/lz_rtf_stream_decompressor_unit.sv =====
// ----------------------------------------------------------------------------
// lz_rtf_stream_decompressor_unit
// Compressed-RTF stream decoder: header parse, pass-through and LZ decoding
// over a 4096-byte ring window held in a synchronous RAM.
// ----------------------------------------------------------------------------
//
//   channel | ports                                  | dir | transaction
//   --------+----------------------------------------+-----+-------------------
//   in      | in_valid in_stall in_byte in_last      | in  | one stream byte
//   out     | out_valid out_stall out_byte byte_valid| out | one decoded byte or
//           | is_last status                         |     | a status-only item
//
// Input: header, flag, literal and pass-through bytes are accepted unless the
// output register cannot load. A reference takes two input bytes, then the
// copy unit does one window read per cycle while the input is stalled.
// Reset: asynchronous, active low; no window clearing pass is needed, since
// positions below 207 read the dictionary ROM and every higher position read
// within a stream has been written earlier in the same stream.
// Stalls: out_stall freezes the output register and the copy pipeline;
// in_stall is raised while a copy runs or the output register cannot load.
//
// Decoding notes:
//  - Bytes 4..7 of the header are the raw length, 8..11 the format word.
//  - A flag byte governs eight tokens, LSB first; a set bit is a two-byte
//    reference (12-bit offset, 4-bit length + 2).
//  - A reference that resolves to the write position is the end marker; one
//    that resolves below position 0 copies nothing.
//  - After the stream ends, bytes are dropped until the one with in_last.
//  - Every in_last byte returns the stream state to its post-reset values.
// ----------------------------------------------------------------------------
module lz_rtf_stream_decompressor_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       is_last,
    output logic [1:0] status
);
    import lzrtf_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PASS,
        PH_FLAG,
        PH_TOKEN,
        PH_REF2,
        PH_COPY,
        PH_DRAIN
    } phase_t;

    phase_t           state_reg;
    logic [3:0]       hc_reg;          // header byte count
    logic [CNT_W-1:0] raw_reg;
    logic [31:0]      fmt_reg;
    logic [7:0]       flag_reg;
    logic [2:0]       fidx_reg;
    logic [7:0]       refh_reg;
    logic [POS_W-1:0] wp_reg;
    logic [CNT_W-1:0] prod_reg;
    logic             copy_end_reg;

    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             byte_valid_reg;
    logic             is_last_reg;
    status_t          status_reg;

    // handshake
    logic adv;
    logic acc;
    logic take;

    // copy unit
    copy_cmd_t cmd;
    win_wr_t   wr;
    logic      cu_valid;
    logic [7:0] cu_data;
    logic      cu_last;
    logic      cu_busy;

    // token decode
    logic             flag_bit;
    logic [2:0]       fidx_inc;
    phase_t           tok_next;
    logic [CNT_W-1:0] prod_inc;
    logic             lit_hit;

    // reference resolve
    logic [WIN_AW-1:0]       o12;
    logic [POS_W-WIN_AW-1:0] wp_hi;
    logic [POS_W-1:0]        base;
    logic [POS_W-1:0]        off;
    logic                    above;
    logic                    below;
    logic                    at_wp;
    logic [LEN_W-1:0]        rlen;
    logic [CNT_W-1:0]        rem;
    logic                    hit;

    // item produced by an accepted byte
    logic       item_v;
    logic [7:0] item_byte;
    logic       item_bv;
    logic       item_last;
    status_t    item_st;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg == PH_COPY) || !adv;
    assign acc      = in_valid && !in_stall;
    assign take     = cu_valid && adv;

    assign flag_bit = flag_reg[fidx_reg];
    assign fidx_inc = fidx_reg + 3'd1;
    assign tok_next = (fidx_inc == 3'd0) ? PH_FLAG : PH_TOKEN;
    assign prod_inc = prod_reg + CNT_W'(1);
    assign lit_hit  = (prod_inc == raw_reg);

    // offset is taken in the window block of the write position, else the
    // previous block; no previous block means before the stream start
    assign o12   = {refh_reg, in_byte[7:4]};
    assign wp_hi = wp_reg[POS_W-1:WIN_AW];
    assign base  = {wp_hi, o12};
    assign above = base > wp_reg;
    assign below = above && (wp_hi == '0);
    assign off   = above ? {wp_hi - (POS_W-WIN_AW)'(1), o12} : base;
    assign at_wp = !below && (off == wp_reg);
    assign rlen  = LEN_W'(in_byte[3:0]) + LEN_W'(2);
    assign rem   = raw_reg - prod_reg;
    assign hit   = rem <= CNT_W'(rlen);

    assign cmd.start = acc && (state_reg == PH_REF2) && !in_last && !at_wp && !below;
    assign cmd.off   = off;
    assign cmd.len   = hit ? rem[LEN_W-1:0] : rlen;
    assign cmd.ends  = hit;

    assign wr.en   = (acc && (state_reg == PH_TOKEN) && !flag_bit) || take;
    assign wr.addr = wp_reg[WIN_AW-1:0];
    assign wr.data = take ? cu_data : in_byte;

    lzrtf_copy_unit u_copy (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .wr       (wr),
        .take     (take),
        .cu_valid (cu_valid),
        .cu_data  (cu_data),
        .cu_last  (cu_last),
        .busy     (cu_busy)
    );

    always_comb
    begin
        item_v    = 1'b0;
        item_byte = 8'h00;
        item_bv   = 1'b0;
        item_last = 1'b1;
        item_st   = STATUS_OK;
        unique case (state_reg)
            PH_HEADER:
            begin
                if (hc_reg != 4'd15)
                begin
                    if (in_last)
                    begin
                        item_v  = 1'b1;
                        item_st = STATUS_SHORT;
                    end
                end
                else if (fmt_reg == FMT_PLAIN)
                begin
                    item_v = in_last;
                end
                else if (fmt_reg == FMT_LZ)
                begin
                    item_v = in_last || (raw_reg == '0);
                end
                else
                begin
                    item_v  = 1'b1;
                    item_st = STATUS_FORMAT;
                end
            end
            PH_PASS:
            begin
                item_v    = 1'b1;
                item_byte = in_byte;
                item_bv   = 1'b1;
                item_last = in_last;
            end
            PH_FLAG:
            begin
                item_v = in_last;
            end
            PH_TOKEN:
            begin
                if (!flag_bit)
                begin
                    item_v    = 1'b1;
                    item_byte = in_byte;
                    item_bv   = 1'b1;
                    item_last = in_last || lit_hit;
                end
                else
                begin
                    item_v = in_last;
                end
            end
            PH_REF2:
            begin
                item_v = in_last || at_wp;
            end
            PH_COPY:
            begin
                item_v = 1'b0;
            end
            PH_DRAIN:
            begin
                item_v = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= PH_HEADER;
            hc_reg         <= '0;
            raw_reg        <= '0;
            fmt_reg        <= '0;
            flag_reg       <= '0;
            fidx_reg       <= '0;
            refh_reg       <= '0;
            wp_reg         <= POS_W'(PREFIX_LENGTH);
            prod_reg       <= '0;
            copy_end_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= '0;
            byte_valid_reg <= 1'b0;
            is_last_reg    <= 1'b0;
            status_reg     <= STATUS_OK;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (wr.en)
            begin
                wp_reg   <= wp_reg + POS_W'(1);
                prod_reg <= prod_inc;
            end

            // copy output
            if (take)
            begin
                out_valid_reg  <= 1'b1;
                out_byte_reg   <= cu_data;
                byte_valid_reg <= 1'b1;
                is_last_reg    <= cu_last;
                status_reg     <= STATUS_OK;
            end

            if ((state_reg == PH_COPY) && !cu_busy)
            begin
                if (copy_end_reg)
                begin
                    state_reg <= PH_DRAIN;
                end
                else
                begin
                    fidx_reg  <= fidx_inc;
                    state_reg <= tok_next;
                end
            end

            if (acc)
            begin
                if (item_v)
                begin
                    out_valid_reg  <= 1'b1;
                    out_byte_reg   <= item_byte;
                    byte_valid_reg <= item_bv;
                    is_last_reg    <= item_last;
                    status_reg     <= item_st;
                end

                unique case (state_reg)
                    PH_HEADER:
                    begin
                        hc_reg <= hc_reg + 4'd1;
                        if (hc_reg[3:2] == 2'd1)
                        begin
                            raw_reg[8*hc_reg[1:0] +: 8] <= in_byte;
                        end
                        if (hc_reg[3:2] == 2'd2)
                        begin
                            fmt_reg[8*hc_reg[1:0] +: 8] <= in_byte;
                        end
                        if (hc_reg == 4'd15)
                        begin
                            if (fmt_reg == FMT_PLAIN)
                            begin
                                state_reg <= PH_PASS;
                            end
                            else if ((fmt_reg == FMT_LZ) && (raw_reg != '0))
                            begin
                                state_reg <= PH_FLAG;
                            end
                            else
                            begin
                                state_reg <= PH_DRAIN;
                            end
                        end
                    end
                    PH_PASS:
                    begin
                        state_reg <= PH_PASS;
                    end
                    PH_FLAG:
                    begin
                        flag_reg  <= in_byte;
                        fidx_reg  <= '0;
                        state_reg <= PH_TOKEN;
                    end
                    PH_TOKEN:
                    begin
                        if (flag_bit)
                        begin
                            refh_reg  <= in_byte;
                            state_reg <= PH_REF2;
                        end
                        else if (lit_hit)
                        begin
                            state_reg <= PH_DRAIN;
                        end
                        else
                        begin
                            fidx_reg  <= fidx_inc;
                            state_reg <= tok_next;
                        end
                    end
                    PH_REF2:
                    begin
                        if (at_wp)
                        begin
                            state_reg <= PH_DRAIN;
                        end
                        else if (below)
                        begin
                            fidx_reg  <= fidx_inc;
                            state_reg <= tok_next;
                        end
                        else
                        begin
                            copy_end_reg <= hit;
                            state_reg    <= PH_COPY;
                        end
                    end
                    PH_COPY:
                    begin
                        state_reg <= PH_COPY;
                    end
                    PH_DRAIN:
                    begin
                        state_reg <= PH_DRAIN;
                    end
                endcase

                // end of input buffer: back to the post-reset stream state
                if (in_last)
                begin
                    state_reg <= PH_HEADER;
                    hc_reg    <= '0;
                    raw_reg   <= '0;
                    fmt_reg   <= '0;
                    flag_reg  <= '0;
                    fidx_reg  <= '0;
                    refh_reg  <= '0;
                    wp_reg    <= POS_W'(PREFIX_LENGTH);
                    prod_reg  <= '0;
                end
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign is_last    = is_last_reg;
    assign status     = status_reg;

endmodule

// ===== sim/lz_rtf_stream_decompressor_unit_tb.sv =====
// ----------------------------------------------------------------------------
// lz_rtf_stream_decompressor_unit_tb
// Self-checking testbench for the compressed-RTF stream decoder. Whole
// streams are built in the bench: short and bad headers, pass-through and
// LZ streams. They are fed one byte per transaction. An in-bench decoder
// predicts every result transaction and each one the block returns is
// checked in order, field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module lz_rtf_stream_decompressor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lzrtf_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RANDOM_ITEMS = 200;
    localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction on either side
    localparam int SETTLE_TICKS = 64;    // settle time after the last expected result

    // decoder state of the in-bench model
    typedef enum logic [2:0] {
        ST_HEADER,
        ST_PASS,
        ST_FLAG,
        ST_TOKEN,
        ST_REF_LO,
        ST_SKIP
    } stage_t;

    // one result transaction
    typedef struct {
        logic [7:0] data;
        logic       valid;
        logic       last;
        status_t    st;
    } decoded_item_t;

    // ------------------------------------------------------------------------
    // Expected-output tracker: decodes accepted input bytes on its own copy
    // of the window and checks every result transaction against the oldest
    // predicted one.
    // ------------------------------------------------------------------------
    class decoded_stream_tracker;
        logic [7:0]      window [WINDOW_SIZE];
        longint unsigned wr_pos;
        logic [31:0]     out_count;
        int unsigned     hdr_count;
        logic [31:0]     raw_len;
        logic [31:0]     fmt_word;
        logic [7:0]      flags;
        int unsigned     bit_idx;
        logic [7:0]      ref_hi;
        stage_t          stage;
        decoded_item_t   expected_q[$];
        int unsigned     mismatch_count;

        function new();
            mismatch_count = 0;
            clear_state();
        endfunction

        // stream state reset; window preset: dictionary text, zeros above it
        function void clear_state();
            string dict;
            int i;
            dict = "{\\rtf1\\ansi\\mac\\deff0\\deftab720{\\fonttbl;}";
            dict = {dict, "{\\f0\\fnil \\froman \\fswiss \\fmodern \\fscript "};
            dict = {dict, "\\fdecor MS Sans SerifSymbolArialTimes New RomanCourier"};
            dict = {dict, "{\\colortbl\\red0\\green0\\blue0\015\012\\par "};
            dict = {dict, "\\pard\\plain\\f0\\fs20\\b\\i\\u\\tab\\tx"};
            for (i = 0; i < WINDOW_SIZE; i++)
            begin
                window[i] = (i < dict.len() && i < PREFIX_LENGTH) ? dict[i] : 8'h00;
            end
            wr_pos    = PREFIX_LENGTH;
            out_count = '0;
            hdr_count = 0;
            raw_len   = '0;
            fmt_word  = '0;
            flags     = '0;
            bit_idx   = 0;
            ref_hi    = '0;
            stage     = ST_HEADER;
        endfunction

        function void put_decoded(ref decoded_item_t step_q[$], input logic [7:0] b);
            decoded_item_t item;
            window[wr_pos[11:0]] = b;
            wr_pos++;
            out_count++;
            item.data  = b;
            item.valid = 1'b1;
            item.last  = 1'b0;
            item.st    = STATUS_OK;
            step_q.push_back(item);
        endfunction

        function void next_token();
            bit_idx = (bit_idx + 1) & 7;
            stage   = (bit_idx == 0) ? ST_FLAG : ST_TOKEN;
        endfunction

        // one accepted input transaction
        function void take_stream_byte(logic [7:0] b, logic last);
            decoded_item_t   step_q[$];
            decoded_item_t   item;
            bit              ended;
            bit              below;
            status_t         st;
            longint unsigned off;
            longint unsigned len;
            ended = 1'b0;
            below = 1'b0;
            st    = STATUS_OK;
            case (stage)
                ST_HEADER:
                begin
                    if (hdr_count >= 4 && hdr_count < 8)
                        raw_len[8*(hdr_count-4) +: 8] = b;
                    else if (hdr_count >= 8 && hdr_count < 12)
                        fmt_word[8*(hdr_count-8) +: 8] = b;
                    hdr_count++;
                    if (hdr_count < 16)
                    begin
                        if (last)
                        begin
                            ended = 1'b1;
                            st    = STATUS_SHORT;
                        end
                    end
                    else if (fmt_word == FMT_PLAIN)
                    begin
                        stage = ST_PASS;
                        ended = last;
                    end
                    else if (fmt_word == FMT_LZ)
                    begin
                        stage = ST_FLAG;
                        ended = (raw_len == 0) || last;
                    end
                    else
                    begin
                        ended = 1'b1;
                        st    = STATUS_FORMAT;
                    end
                end
                ST_PASS:
                begin
                    item.data  = b;
                    item.valid = 1'b1;
                    item.last  = 1'b0;
                    item.st    = STATUS_OK;
                    step_q.push_back(item);
                    ended = last;
                end
                ST_FLAG:
                begin
                    flags   = b;
                    bit_idx = 0;
                    stage   = ST_TOKEN;
                    ended   = last;
                end
                ST_TOKEN:
                begin
                    if (!flags[bit_idx])
                    begin
                        put_decoded(step_q, b);
                        if (last || out_count == raw_len)
                            ended = 1'b1;
                        else
                            next_token();
                    end
                    else
                    begin
                        ref_hi = b;
                        stage  = ST_REF_LO;
                        ended  = last;
                    end
                end
                ST_REF_LO:
                begin
                    if (last)
                    begin
                        ended = 1'b1;  // reference cut by end of input is dropped
                    end
                    else
                    begin
                        off = {52'd0, ref_hi, b[7:4]};
                        len = b[3:0] + 2;
                        off += (wr_pos >> 12) << 12;
                        if (off > wr_pos)
                        begin
                            if (off < WINDOW_SIZE)
                                below = 1'b1;
                            else
                                off -= WINDOW_SIZE;
                        end
                        if (!below && off == wr_pos)
                        begin
                            ended = 1'b1;  // end marker
                        end
                        else
                        begin
                            // byte-wise copy so overlapping sources see fresh data
                            if (!below)
                            begin
                                while (len > 0 && out_count != raw_len)
                                begin
                                    put_decoded(step_q, window[off[11:0]]);
                                    off++;
                                    len--;
                                end
                            end
                            if (out_count == raw_len)
                                ended = 1'b1;
                            else
                                next_token();
                        end
                    end
                end
                default:
                begin
                    if (last)
                        clear_state();
                    return;
                end
            endcase

            if (ended)
            begin
                if (step_q.size() > 0 && st == STATUS_OK)
                begin
                    step_q[step_q.size()-1].last = 1'b1;
                end
                else
                begin
                    item.data  = 8'h00;
                    item.valid = 1'b0;
                    item.last  = 1'b1;
                    item.st    = st;
                    step_q.push_back(item);
                end
                if (last)
                    clear_state();
                else
                    stage = ST_SKIP;
            end
            foreach (step_q[i])
                expected_q.push_back(step_q[i]);
        endfunction

        // one accepted result transaction
        function void check_decoded(logic [7:0] data, logic valid, logic last, logic [1:0] st);
            decoded_item_t e;
            if (expected_q.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result: byte %02h valid %0b last %0b status %0d",
                         $time, data, valid, last, st);
                return;
            end
            e = expected_q.pop_front();
            if (data !== e.data || valid !== e.valid || last !== e.last || st !== e.st)
            begin
                mismatch_count++;
                $display("%0t: mismatch: expected byte %02h valid %0b last %0b status %0d,",
                         $time, e.data, e.valid, e.last, e.st);
                $display("%0t:           actual   byte %02h valid %0b last %0b status %0d",
                         $time, data, valid, last, st);
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and its signals
    // ------------------------------------------------------------------------
    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       is_last;
    logic [1:0] status;

    lz_rtf_stream_decompressor_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .is_last    (is_last),
        .status     (status)
    );

    decoded_stream_tracker tracker;
    int unsigned           idle_cycles;
    bit                    calm_input;   // current stream is sent back to back
    logic [8:0]            stream_q[$];  // {last, byte} of the stream being built

    initial clk = 1'b0;
    always #(CLK_PERIOD/2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Monitor: both channels are sampled at the same edge in one process, so
    // input prediction always precedes result checking within a time step.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.take_stream_byte(in_byte, in_last);
            if (out_valid && !out_stall)
                tracker.check_decoded(out_byte, byte_valid, is_last, status);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Output back-pressure: random stall bursts, with an occasional long
    // stretch that never stalls.
    initial
    begin
        int run;
        int gap;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
            repeat (run) @(posedge clk);
            gap = rand_gap();
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run if neither side moves for too long.
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("%0t: no transaction for %0d cycles, %0d results still expected",
                 $time, IDLE_LIMIT, tracker.outstanding());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stream building
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        stream_q.push_back({1'b0, b});
    endtask

    task automatic mark_last();
        stream_q[stream_q.size()-1][8] = 1'b1;
    endtask

    // 16-byte header: size (ignored), raw length, format word, CRC (ignored)
    task automatic push_header(input logic [31:0] raw, input logic [31:0] fmt);
        int j;
        for (j = 0; j < 4; j++)
            push_byte(8'($urandom_range(0, 255)));
        for (j = 0; j < 4; j++)
            push_byte(raw[8*j +: 8]);
        for (j = 0; j < 4; j++)
            push_byte(fmt[8*j +: 8]);
        for (j = 0; j < 4; j++)
            push_byte(8'($urandom_range(0, 255)));
    endtask

    // LZ token stream. The write position is tracked only roughly (every
    // reference counted as a full copy), enough to aim back references at
    // written data. Long mode gives max-length back references only.
    task automatic push_lz_body(input int n_tokens, input int ref_pct,
                                input bit long_mode, output longint unsigned produced);
        longint unsigned pos;
        longint unsigned d;
        logic [7:0]      flag_bits;
        logic [11:0]     off;
        logic [3:0]      ln;
        int              k;
        int              j;
        int              pick;
        pos       = PREFIX_LENGTH;
        flag_bits = '0;
        for (k = 0; k < n_tokens; k++)
        begin
            if (k % 8 == 0)
            begin
                for (j = 0; j < 8; j++)
                    flag_bits[j] = ($urandom_range(0, 99) < ref_pct);
                push_byte(flag_bits);
            end
            if (!flag_bits[k % 8])
            begin
                push_byte(8'($urandom_range(0, 255)));
                pos++;
            end
            else
            begin
                pick = long_mode ? $urandom_range(0, 74) : $urandom_range(0, 99);
                ln   = long_mode ? 4'hf : 4'($urandom_range(0, 15));
                if (pick < 35)
                begin
                    d   = $urandom_range(1, 4);  // short distance, overlapping copy
                    off = 12'(pos - d);
                end
                else if (pick < 75)
                begin
                    d   = $urandom_range(1, (pos < 4095) ? int'(pos) : 4095);
                    off = 12'(pos - d);
                end
                else if (pick < 87)
                    off = 12'($urandom_range(0, PREFIX_LENGTH - 1));  // dictionary
                else if (pick < 93)
                    off = 12'(pos);                                   // end marker
                else
                    off = 12'($urandom_range(0, 4095));               // anywhere
                push_byte(off[11:4]);
                push_byte({off[3:0], ln});
                if (off != 12'(pos))
                    pos += ln + 2;
            end
        end
        produced = pos - PREFIX_LENGTH;
    endtask

    // LZ stream with a raw length picked around the produced size, at times
    // cut short so that input ends inside a token.
    task automatic build_lz_stream(input bit long_mode, output int n_items);
        longint unsigned est;
        logic [31:0]     raw;
        int              n_tokens;
        int              pick;
        int              j;
        stream_q.delete();
        push_header(32'h0, FMT_LZ);
        if (long_mode)
            n_tokens = 8 * 30;
        else if ($urandom_range(0, 4) == 0)
            n_tokens = $urandom_range(25, 64);
        else
            n_tokens = $urandom_range(1, 24);
        push_lz_body(n_tokens, long_mode ? 100 : $urandom_range(15, 75), long_mode, est);
        pick = $urandom_range(0, 99);
        if (long_mode)
            raw = 32'hffff_ffff;
        else if (est == 0)
            raw = $urandom_range(1, 8);
        else if (pick < 40)
            raw = 32'(est);
        else if (pick < 65)
            raw = $urandom_range(1, int'(est));
        else if (pick < 90)
            raw = 32'hffff_ffff;
        else
            raw = $urandom();
        for (j = 0; j < 4; j++)
            stream_q[4+j] = {1'b0, raw[8*j +: 8]};
        if (!long_mode && stream_q.size() > 17 && $urandom_range(0, 99) < 35)
        begin
            j = $urandom_range(17, stream_q.size() - 1);
            while (stream_q.size() > j)
                void'(stream_q.pop_back());
        end
        mark_last();
        n_items = stream_q.size();
    endtask

    // ------------------------------------------------------------------------
    // Driver: one transaction per stream byte, random gaps between them
    // ------------------------------------------------------------------------
    task automatic send_stream();
        int k;
        int gap;
        calm_input = ($urandom_range(0, 99) < 15);
        for (k = 0; k < stream_q.size(); k++)
        begin
            gap = calm_input ? 0 : rand_gap();
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_byte  <= stream_q[k][7:0];
            in_last  <= stream_q[k][8];
            do
            begin
                @(posedge clk);
            end
            while (!(in_valid && !in_stall));
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int          sent;
        int          n;
        int          kind;
        int          j;
        logic [31:0] fmt;
        tracker  = new();
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_byte  = 8'h00;
        in_last  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: header cut after one byte, header cut after three bytes
        // (both short-header status), then an LZ header that ends the buffer
        // on its 16th byte, which yields a status-only ok transaction.
        stream_q.delete();
        push_byte(8'hff);
        mark_last();
        send_stream();
        stream_q.delete();
        push_byte(8'h00);
        push_byte(8'h80);
        push_byte(8'h7f);
        mark_last();
        send_stream();
        stream_q.delete();
        push_header(32'h8000_0001, FMT_LZ);
        mark_last();
        send_stream();

        // Random streams of every kind; most are well-formed LZ streams.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 8)
            begin
                // header shorter than 16 bytes
                stream_q.delete();
                n = $urandom_range(1, 15);
                for (j = 0; j < n; j++)
                    push_byte(8'($urandom_range(0, 255)));
                mark_last();
            end
            else if (kind < 16)
            begin
                // unknown format word, then bytes that are dropped
                stream_q.delete();
                case ($urandom_range(0, 2))
                    0:       fmt = $urandom();
                    1:       fmt = FMT_LZ ^ (32'd1 << $urandom_range(0, 31));
                    default: fmt = FMT_PLAIN ^ (32'd1 << $urandom_range(0, 31));
                endcase
                push_header($urandom(), fmt);
                n = 16;
                repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(0, 255)));
                mark_last();
            end
            else if (kind < 30)
            begin
                // pass-through, raw length not applied
                stream_q.delete();
                push_header($urandom_range(0, 3), FMT_PLAIN);
                repeat ($urandom_range(0, 12)) push_byte(8'($urandom_range(0, 255)));
                mark_last();
                n = stream_q.size();
            end
            else if (kind < 35)
            begin
                // zero raw length: stream ends right after the header
                stream_q.delete();
                push_header(32'h0, FMT_LZ);
                n = 16;
                repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(0, 255)));
                mark_last();
            end
            else
            begin
                build_lz_stream(1'b0, n);
            end
            send_stream();
            sent += n;
        end
        in_valid <= 1'b0;

        // wait for every predicted transaction, then give the block time
        // to show anything extra
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);

        if (tracker.mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lzrtf_pkg.sv
rtl/lzrtf_window_ram.sv
rtl/lzrtf_copy_unit.sv
rtl/lz_rtf_stream_decompressor_unit.sv
sim/lz_rtf_stream_decompressor_unit_tb.sv
